### rtl/dpt_pkg.sv
// dpt_pkg: shared types, constants and fixed-point helpers for the
// delivery predictability table. No dependencies.
package dpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS + 1;
    localparam int ADDR_W    = 7;
    localparam int TIME_W    = 32;
    localparam int SEC_W     = 16;
    localparam int NODES_DEF = 128;

    localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC_BITS;

    // configuration register indexes
    localparam logic [2:0] REG_SELF  = 3'd0;
    localparam logic [2:0] REG_PENC  = 3'd1;
    localparam logic [2:0] REG_ITYP  = 3'd2;
    localparam logic [2:0] REG_BETA  = 3'd3;
    localparam logic [2:0] REG_GAMMA = 3'd4;
    localparam logic [2:0] REG_TUNIT = 3'd5;

    // operation codes
    localparam logic [1:0] OP_ENC = 2'd0;
    localparam logic [1:0] OP_TR  = 2'd1;

    typedef struct packed {
        logic [TIME_W-1:0] enc_time;
        logic              encountered;
        logic              valid;
        logic [QW-1:0]     pred;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [SEC_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
        logic [SEC_W-1:0]  remainder;
    } div_rsp_t;

    function automatic logic [QW-1:0] q_sat(input logic [QW-1:0] a);
        return (a > Q_ONE) ? Q_ONE : a;
    endfunction

    // truncating Q1.F product; an operand of one passes the other through
    function automatic logic [QW-1:0] q_mul(input logic [QW-1:0] a,
                                            input logic [QW-1:0] b);
        logic [QW-1:0]          sa;
        logic [QW-1:0]          sb;
        logic [2*FRAC_BITS-1:0] prod;
        sa   = q_sat(a);
        sb   = q_sat(b);
        prod = sa[FRAC_BITS-1:0] * sb[FRAC_BITS-1:0];
        if (sa == Q_ONE)
            return sb;
        else if (sb == Q_ONE)
            return sa;
        else
            return {1'b0, prod[2*FRAC_BITS-1:FRAC_BITS]};
    endfunction

endpackage

### rtl/delivery_predictability_table.sv
// delivery_predictability_table: top level, sequencer around the entry RAM.
// Depends on dpt_pkg, dpt_ram, dpt_div.
//
// Per-node delivery predictability table in Q1.16. Pulse start while busy is
// low to hand in one item; exactly one result comes back later on prediction
// and entry_valid, marked by a one-cycle done strobe that cannot be held off,
// and busy is low again in that same cycle, so the next item can be taken at
// the edge that ends the strobe. After reset the block sweeps the entry RAM
// clearing it, one entry per cycle, with busy high throughout the clear.
// From the accepting edge, a query first starts the elapsed-units divide,
// waits on the bit-serial divider, then does two RAM reads and a dispatch
// step before its done strobe. An encounter item with an in-range peer, and a
// transitive item to an in-range node other than self, then write back in
// one more state. When time has gone backwards the divide is skipped. When at
// least one whole time unit has elapsed, the gamma power is computed by
// square-and-multiply over the significant bits of the unit count, then a
// read-modify-write sweep runs over the RAM, one entry per cycle through its
// single read and write ports. An encounter within the typical interval adds
// a gain-scaling divide before its write-back.
// Configuration writes take effect at once and belong in idle periods only.
module delivery_predictability_table #(
    parameter int NODES = dpt_pkg::NODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         config_write,
    input  logic [2:0]                   config_index,
    input  logic [dpt_pkg::QW-1:0]       config_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic [dpt_pkg::ADDR_W-1:0]   peer_address,
    input  logic [dpt_pkg::ADDR_W-1:0]   node_address,
    input  logic [dpt_pkg::QW-1:0]       peer_prediction,
    input  logic [dpt_pkg::TIME_W-1:0]   now_seconds,
    output logic                         done,
    output logic [dpt_pkg::QW-1:0]       prediction,
    output logic                         entry_valid
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int QW = dpt_pkg::QW;
    localparam int TW = dpt_pkg::TIME_W;
    localparam int SW = dpt_pkg::SEC_W;
    localparam int AD = dpt_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST = AW'(NODES - 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_AGE_CHK  = 4'd2;
    localparam logic [3:0] S_AGE_DIV  = 4'd3;
    localparam logic [3:0] S_POW      = 4'd4;
    localparam logic [3:0] S_SWEEP    = 4'd5;
    localparam logic [3:0] S_SWP_END  = 4'd6;
    localparam logic [3:0] S_RD_B     = 4'd7;
    localparam logic [3:0] S_GOT_B    = 4'd8;
    localparam logic [3:0] S_GOT_C    = 4'd9;
    localparam logic [3:0] S_DISPATCH = 4'd10;
    localparam logic [3:0] S_ENC_MUL  = 4'd11;
    localparam logic [3:0] S_ENC_DIV  = 4'd12;
    localparam logic [3:0] S_ENC_UPD  = 4'd13;
    localparam logic [3:0] S_TR2      = 4'd14;

    // configuration registers
    logic [AD-1:0] self_reg;
    logic [QW-1:0] penc_max_reg;
    logic [SW-1:0] ityp_reg;
    logic [QW-1:0] beta_reg;
    logic [QW-1:0] gamma_reg;
    logic [SW-1:0] tunit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_reg     <= '0;
            penc_max_reg <= QW'(32768);
            ityp_reg     <= SW'(1800);
            beta_reg     <= QW'(58982);
            gamma_reg    <= QW'(65470);
            tunit_reg    <= SW'(30);
        end
        else if (config_write)
        begin
            unique case (config_index)
                dpt_pkg::REG_SELF:  self_reg     <= config_data[AD-1:0];
                dpt_pkg::REG_PENC:  penc_max_reg <= config_data;
                dpt_pkg::REG_ITYP:  ityp_reg     <= config_data[SW-1:0];
                dpt_pkg::REG_BETA:  beta_reg     <= config_data;
                dpt_pkg::REG_GAMMA: gamma_reg    <= config_data;
                dpt_pkg::REG_TUNIT: tunit_reg    <= config_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    logic [3:0]      state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            wb_reg, wb_next;
    logic [AW-1:0]   wb_idx_reg, wb_idx_next;
    logic [TW-1:0]   last_age_reg, last_age_next;
    logic            done_reg, done_next;
    // item and working payload
    logic [1:0]      op_reg, op_next;
    logic [AD-1:0]   peer_reg, peer_next;
    logic [AD-1:0]   node_reg, node_next;
    logic [QW-1:0]   pbc_reg, pbc_next;
    logic [TW-1:0]   now_reg, now_next;
    logic [TW-1:0]   exp_reg, exp_next;
    logic [QW-1:0]   pow_r_reg, pow_r_next;   // gamma power, then sweep factor
    logic [QW-1:0]   pow_b_reg, pow_b_next;
    dpt_pkg::entry_t ent_b_reg, ent_b_next;
    dpt_pkg::entry_t ent_c_reg, ent_c_next;
    logic [QW-1:0]   penc_reg, penc_next;
    logic [SW-1:0]   dt_reg, dt_next;
    logic [QW-1:0]   tmp_reg, tmp_next;
    logic [QW-1:0]   pred_reg, pred_next;
    logic            vld_reg, vld_next;

    // RAM and divider hookup
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    dpt_pkg::entry_t   ram_wdata;
    logic [AW-1:0]     ram_raddr;
    dpt_pkg::entry_t   ram_rdata;
    dpt_pkg::div_req_t div_req;
    dpt_pkg::div_rsp_t div_rsp;

    dpt_ram #(
        .WIDTH($bits(dpt_pkg::entry_t)),
        .DEPTH(NODES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    dpt_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    logic            peer_in;
    logic            node_in;
    logic [SW-1:0]   tunit_eff;
    logic [TW-1:0]   dt_full;
    logic [QW-1:0]   cand;
    logic [QW:0]     p_sum;
    dpt_pkg::entry_t wb_ent;

    assign peer_in   = 32'(peer_reg) < NODES;
    assign node_in   = 32'(node_reg) < NODES;
    assign tunit_eff = (tunit_reg == '0) ? SW'(1) : tunit_reg;
    assign dt_full   = (now_reg >= ent_b_reg.enc_time) ? now_reg - ent_b_reg.enc_time : '0;
    assign cand      = dpt_pkg::q_mul(tmp_reg, beta_reg);
    assign p_sum     = {1'b0, ent_b_reg.pred}
                     + {1'b0, dpt_pkg::q_mul(dpt_pkg::Q_ONE - ent_b_reg.pred, penc_reg)};

    // aging write-back of the entry read in the previous cycle
    always_comb
    begin
        wb_ent = ram_rdata;
        if (ram_rdata.valid)
            wb_ent.pred = dpt_pkg::q_mul(ram_rdata.pred, pow_r_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        wb_next       = 1'b0;
        wb_idx_next   = wb_idx_reg;
        last_age_next = last_age_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        peer_next     = peer_reg;
        node_next     = node_reg;
        pbc_next      = pbc_reg;
        now_next      = now_reg;
        exp_next      = exp_reg;
        pow_r_next    = pow_r_reg;
        pow_b_next    = pow_b_reg;
        ent_b_next    = ent_b_reg;
        ent_c_next    = ent_c_reg;
        penc_next     = penc_reg;
        dt_next       = dt_reg;
        tmp_next      = tmp_reg;
        pred_next     = pred_reg;
        vld_next      = vld_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = '0;
        ram_raddr     = cnt_reg;
        div_req       = '0;

        if (wb_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wb_idx_reg;
            ram_wdata = wb_ent;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    peer_next  = peer_address;
                    node_next  = node_address;
                    pbc_next   = dpt_pkg::q_sat(peer_prediction);
                    now_next   = now_seconds;
                    state_next = S_AGE_CHK;
                end
            end
            S_AGE_CHK:
            begin
                if (now_reg < last_age_reg)
                    state_next = S_RD_B;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = now_reg - last_age_reg;
                    div_req.divisor  = tunit_eff;
                    state_next       = S_AGE_DIV;
                end
            end
            S_AGE_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient == '0)
                        state_next = S_RD_B;
                    else
                    begin
                        exp_next      = div_rsp.quotient;
                        pow_r_next    = dpt_pkg::Q_ONE;
                        pow_b_next    = dpt_pkg::q_sat(gamma_reg);
                        last_age_next = now_reg - TW'(div_rsp.remainder);
                        state_next    = S_POW;
                    end
                end
            end
            S_POW:
            begin
                // square-and-multiply, lowest exponent bit first
                if (exp_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = S_SWEEP;
                end
                else
                begin
                    if (exp_reg[0])
                        pow_r_next = dpt_pkg::q_mul(pow_r_reg, pow_b_reg);
                    pow_b_next = dpt_pkg::q_mul(pow_b_reg, pow_b_reg);
                    exp_next   = exp_reg >> 1;
                end
            end
            S_SWEEP:
            begin
                ram_raddr   = cnt_reg;
                wb_next     = 1'b1;
                wb_idx_next = cnt_reg;
                cnt_next    = cnt_reg + AW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SWP_END;
                end
            end
            S_SWP_END:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                ram_raddr  = AW'(peer_reg);
                state_next = S_GOT_B;
            end
            S_GOT_B:
            begin
                ent_b_next = (peer_in && ram_rdata.valid) ? ram_rdata : '0;
                ram_raddr  = AW'(node_reg);
                state_next = S_GOT_C;
            end
            S_GOT_C:
            begin
                ent_c_next = (node_in && ram_rdata.valid) ? ram_rdata : '0;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (op_reg == dpt_pkg::OP_ENC)
                begin
                    penc_next = dpt_pkg::q_sat(penc_max_reg);
                    if (!peer_in)
                    begin
                        pred_next  = '0;
                        vld_next   = 1'b0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (ent_b_reg.valid && ent_b_reg.encountered
                             && dt_full < TW'(ityp_reg))
                    begin
                        dt_next    = dt_full[SW-1:0];
                        state_next = S_ENC_MUL;
                    end
                    else
                        state_next = S_ENC_UPD;
                end
                else if (op_reg == dpt_pkg::OP_TR && node_in && node_reg != self_reg)
                begin
                    tmp_next   = dpt_pkg::q_mul(ent_b_reg.pred, pbc_reg);
                    state_next = S_TR2;
                end
                else
                begin
                    pred_next  = ent_c_reg.pred;
                    vld_next   = ent_c_reg.valid;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ENC_MUL:
            begin
                // gain scaled by elapsed time over the typical interval
                div_req.start    = 1'b1;
                div_req.dividend = TW'(penc_reg * dt_reg);
                div_req.divisor  = ityp_reg;
                state_next       = S_ENC_DIV;
            end
            S_ENC_DIV:
            begin
                if (div_rsp.done)
                begin
                    penc_next  = QW'(div_rsp.quotient);
                    state_next = S_ENC_UPD;
                end
            end
            S_ENC_UPD:
            begin
                ram_we                = 1'b1;
                ram_waddr             = AW'(peer_reg);
                ram_wdata.pred        = dpt_pkg::q_sat(p_sum[QW-1:0] | {QW{p_sum[QW]}});
                ram_wdata.valid       = 1'b1;
                ram_wdata.encountered = 1'b1;
                ram_wdata.enc_time    = now_reg;
                pred_next             = ram_wdata.pred;
                vld_next              = 1'b1;
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end
            S_TR2:
            begin
                ram_we                = 1'b1;
                ram_waddr             = AW'(node_reg);
                ram_wdata             = ent_c_reg;
                ram_wdata.valid       = 1'b1;
                ram_wdata.pred        = (ent_c_reg.pred < cand) ? cand : ent_c_reg.pred;
                pred_next             = ram_wdata.pred;
                vld_next              = 1'b1;
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            wb_reg       <= 1'b0;
            last_age_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            wb_reg       <= wb_next;
            last_age_reg <= last_age_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_idx_reg <= wb_idx_next;
        op_reg     <= op_next;
        peer_reg   <= peer_next;
        node_reg   <= node_next;
        pbc_reg    <= pbc_next;
        now_reg    <= now_next;
        exp_reg    <= exp_next;
        pow_r_reg  <= pow_r_next;
        pow_b_reg  <= pow_b_next;
        ent_b_reg  <= ent_b_next;
        ent_c_reg  <= ent_c_next;
        penc_reg   <= penc_next;
        dt_reg     <= dt_next;
        tmp_reg    <= tmp_next;
        pred_reg   <= pred_next;
        vld_reg    <= vld_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign prediction  = pred_reg;
    assign entry_valid = vld_reg;

endmodule

### rtl/dpt_ram.sv
// dpt_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module dpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### rtl/dpt_div.sv
// dpt_div: restoring divider, one quotient bit per cycle.
// Depends on dpt_pkg.
module dpt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dpt_pkg::div_req_t req,
    output dpt_pkg::div_rsp_t rsp
);

    localparam int DW = dpt_pkg::TIME_W;
    localparam int SW = dpt_pkg::SEC_W;
    localparam int CW = $clog2(DW);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dvs_reg, dvs_next;
    logic [SW:0]   shifted;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[DW-1]};
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = SW'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/dpt_chk.sv
// dpt_chk: port-level checks on the delivery predictability table, bound in.
// Depends on dpt_pkg and delivery_predictability_table.
module dpt_chk (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic [dpt_pkg::QW-1:0] prediction,
    input logic                   entry_valid
);

    // done never asserted in consecutive cycles, so results never come two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !entry_valid) |-> (prediction == '0))
        else $error("missing entry reported nonzero");

    a_pred_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (prediction <= dpt_pkg::Q_ONE))
        else $error("prediction above one");

endmodule

bind delivery_predictability_table dpt_chk u_dpt_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .prediction (prediction),
    .entry_valid(entry_valid)
);
